>>> hdl/assert_macros.svh
// Assertion macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that an expression is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> hdl/rgb2hsv_pkg.sv
// Widths, constants, types and the divider step of the RGB to HSV converter.
package rgb2hsv_pkg;

    localparam int CH_W           = 8;
    localparam int HUE_W          = 15;
    localparam int QUOT_W         = 12;
    localparam int NUM_W          = CH_W + QUOT_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;

    // Hue in 1/64 degree units
    localparam logic [HUE_W-1:0] HUE_120 = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_240 = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_360 = 15'd23040;
    localparam logic [NUM_W-1:0] HUE_60_SCALE = 20'd3840;
    localparam logic [NUM_W-1:0] SAT_SCALE    = 20'd255;

    typedef logic [1:0] t_sector;
    localparam t_sector SECT_RED   = 2'd0;
    localparam t_sector SECT_GREEN = 2'd1;
    localparam t_sector SECT_BLUE  = 2'd2;

    // Partial remainder and the numerator bits still to come, quotient bits shifting in
    typedef struct packed {
        logic [CH_W-1:0]   rem;
        logic [QUOT_W-1:0] word;
    } t_div_lane;

    // Per-pixel data that travels beside the divider lanes
    typedef struct packed {
        t_sector         sector;
        logic            neg;
        logic [CH_W-1:0] bright;
        logic [CH_W-1:0] delta;
    } t_side;

    // One restoring division step: one quotient bit
    function automatic t_div_lane div_step(t_div_lane x, logic [CH_W-1:0] d);
        logic [CH_W:0] trial;
        logic [CH_W:0] diff;
        t_div_lane     y;
        trial = {x.rem, x.word[QUOT_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            y.rem  = diff[CH_W-1:0];
            y.word = {x.word[QUOT_W-2:0], 1'b1};
        end else begin
            y.rem  = trial[CH_W-1:0];
            y.word = {x.word[QUOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

>>> hdl/rgb_to_hsv_converter_core.sv
// Pipelined RGB to HSV pixel converter, one pixel per clock unless the output stalls.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------------------
//   pixel in | input     | i_in_valid / o_in_ready   | i_red, i_green, i_blue
//   hsv out  | output    | o_out_valid / i_out_ready | o_hue, o_saturation, o_brightness
//
// From request acceptance to o_out_valid a pixel passes one stage for max, min and
// sector, one for the numerators, six divider stages of two quotient bits each, one output.
// One pixel per clock unless the output stalls; the divider stage count sets the latency.
// Each stage holds when its successor is full and stalled, so bubbles close up and no
// request is dropped or repeated. Reset (i_rst_n low, synchronous) clears all valid bits.

`include "assert_macros.svh"

module rgb_to_hsv_converter_core
    import rgb2hsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CH_W-1:0]   i_red,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_blue,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [HUE_W-1:0]  o_hue,
    output logic [CH_W-1:0]   o_saturation,
    output logic [CH_W-1:0]   o_brightness
);

    // Stage 1 registers
    logic            r_s1_v;
    t_side           r_s1_side;
    logic [CH_W-1:0] r_s1_mag;
    t_side           n_s1_side;
    logic [CH_W-1:0] n_s1_mag;

    // Divider stage registers, entry 0 holds the initial numerators
    logic      r_dv   [0:DIV_STAGES];
    t_div_lane r_dh   [0:DIV_STAGES];
    t_div_lane r_ds   [0:DIV_STAGES];
    t_side     r_side [0:DIV_STAGES];
    t_div_lane n_dh   [0:DIV_STAGES];
    t_div_lane n_ds   [0:DIV_STAGES];

    // Output registers
    logic              r_o_valid;
    logic [HUE_W-1:0]  r_hue;
    logic [CH_W-1:0]   r_sat;
    logic [CH_W-1:0]   r_bright;
    logic [HUE_W-1:0]  n_hue;
    logic [CH_W-1:0]   n_sat;

    // Stage load enables
    logic w_rdy_1;
    logic w_rdy_d [0:DIV_STAGES];
    logic w_rdy_o;

    // Stage 1 helpers
    logic [CH_W-1:0] w_max;
    logic [CH_W-1:0] w_min;
    logic [CH_W-1:0] w_op_a;
    logic [CH_W-1:0] w_op_b;
    logic [CH_W:0]   w_diff;

    // Stage 2 numerators
    logic [NUM_W-1:0] w_num_h;
    logic [NUM_W-1:0] w_num_s;

    // Output helpers
    logic [HUE_W-1:0] w_base;
    logic [HUE_W-1:0] w_q;

    // Ready chain: a stage loads when it is empty or its successor loads
    assign w_rdy_o               = !r_o_valid || i_out_ready;
    assign w_rdy_d[DIV_STAGES]   = !r_dv[DIV_STAGES] || w_rdy_o;
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rdy
        assign w_rdy_d[k] = !r_dv[k] || w_rdy_d[k+1];
    end
    assign w_rdy_1    = !r_s1_v || w_rdy_d[0];
    assign o_in_ready = w_rdy_1;

    // Find max, min, sector and the signed channel difference
    always_comb begin
        w_max = (i_red >= i_green) ? i_red : i_green;
        w_max = (w_max >= i_blue) ? w_max : i_blue;
        w_min = (i_red <= i_green) ? i_red : i_green;
        w_min = (w_min <= i_blue) ? w_min : i_blue;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_s1_side.sector = SECT_RED;
            w_op_a = i_green;
            w_op_b = i_blue;
        end else if (i_green >= i_blue) begin
            n_s1_side.sector = SECT_GREEN;
            w_op_a = i_blue;
            w_op_b = i_red;
        end else begin
            n_s1_side.sector = SECT_BLUE;
            w_op_a = i_red;
            w_op_b = i_green;
        end
        w_diff           = {1'b0, w_op_a} - {1'b0, w_op_b};
        n_s1_side.neg    = w_diff[CH_W];
        n_s1_side.bright = w_max;
        n_s1_side.delta  = w_max - w_min;
        n_s1_mag         = w_diff[CH_W] ? (w_op_b - w_op_a) : w_diff[CH_W-1:0];
    end

    // Form numerators; a negative hue term takes the ceiling, so bias by delta - 1
    always_comb begin
        w_num_h = NUM_W'(r_s1_mag) * HUE_60_SCALE;
        if (r_s1_side.neg) begin
            w_num_h = w_num_h + NUM_W'(r_s1_side.delta - 8'd1);
        end
        w_num_s = NUM_W'(r_s1_side.delta) * SAT_SCALE;
        n_dh[0] = '{rem: w_num_h[NUM_W-1:QUOT_W], word: w_num_h[QUOT_W-1:0]};
        n_ds[0] = '{rem: w_num_s[NUM_W-1:QUOT_W], word: w_num_s[QUOT_W-1:0]};
    end

    // Advance both divider lanes by BITS_PER_STAGE quotient bits per stage
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        always_comb begin
            n_dh[k] = r_dh[k-1];
            n_ds[k] = r_ds[k-1];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                n_dh[k] = div_step(n_dh[k], r_side[k-1].delta);
                n_ds[k] = div_step(n_ds[k], r_side[k-1].bright);
            end
        end
    end

    // Hue from sector and quotient, zero for black and grey; saturation zero for black
    always_comb begin
        w_q = HUE_W'(r_dh[DIV_STAGES].word);
        case (r_side[DIV_STAGES].sector)
            SECT_RED:   w_base = r_side[DIV_STAGES].neg ? HUE_360 : '0;
            SECT_GREEN: w_base = HUE_120;
            SECT_BLUE:  w_base = HUE_240;
            default:    w_base = '0;
        endcase
        if (r_side[DIV_STAGES].delta == '0) begin
            n_hue = '0;
        end else if (r_side[DIV_STAGES].neg) begin
            n_hue = w_base - w_q;
        end else begin
            n_hue = w_base + w_q;
        end
        if (r_side[DIV_STAGES].bright == '0) begin
            n_sat = '0;
        end else begin
            n_sat = r_ds[DIV_STAGES].word[CH_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_o_valid <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            if (w_rdy_1) begin
                r_s1_v <= i_in_valid;
            end
            if (w_rdy_d[0]) begin
                r_dv[0] <= r_s1_v;
            end
            for (int k = 1; k <= DIV_STAGES; k++) begin
                if (w_rdy_d[k]) begin
                    r_dv[k] <= r_dv[k-1];
                end
            end
            if (w_rdy_o) begin
                r_o_valid <= r_dv[DIV_STAGES];
            end
        end
    end

    // Payload registers, held while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (w_rdy_1) begin
            r_s1_side <= n_s1_side;
            r_s1_mag  <= n_s1_mag;
        end
        if (w_rdy_d[0]) begin
            r_dh[0]   <= n_dh[0];
            r_ds[0]   <= n_ds[0];
            r_side[0] <= r_s1_side;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (w_rdy_d[k]) begin
                r_dh[k]   <= n_dh[k];
                r_ds[k]   <= n_ds[k];
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_rdy_o) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= r_side[DIV_STAGES].bright;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

    // Checks
    `ASSERT_NEVER(a_hue_range, i_clk, i_rst_n, o_out_valid && (o_hue >= HUE_360), "hue out of range")
    `ASSERT_CLK(a_black_zero, i_clk, i_rst_n, (o_out_valid && o_brightness == '0) |-> (o_hue == '0 && o_saturation == '0), "black pixel with nonzero hue or saturation")
    `ASSERT_CLK(a_hue_needs_sat, i_clk, i_rst_n, (o_out_valid && o_hue != '0) |-> (o_saturation != '0), "hue without saturation")
    `ASSERT_CLK(a_rem_below_div, i_clk, i_rst_n, (r_dv[DIV_STAGES] && r_side[DIV_STAGES].delta != '0) |-> (r_dh[DIV_STAGES].rem < r_side[DIV_STAGES].delta), "hue divider remainder not below divisor")

endmodule

>>> test/tb_rgb_to_hsv_converter_core.sv
// Testbench for the pipelined RGB to HSV pixel converter.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_core
    import rgb2hsv_pkg::*;
();

    localparam int SIXTY_DEG     = 3840;   // 60 degrees in 1/64 degree steps
    localparam int FULL_TURN     = 23040;  // 360 degrees in 1/64 degree steps
    localparam int SETTLE_CYCLES = 20;     // settling wait after the last result
    localparam int HOLD_CYCLES   = 250;
    localparam int RUN_LIMIT_NS  = 2000000;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  bright;
    } t_hsv;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [CH_W-1:0]   i_red;
    logic [CH_W-1:0]   i_green;
    logic [CH_W-1:0]   i_blue;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [HUE_W-1:0]  o_hue;
    logic [CH_W-1:0]   o_saturation;
    logic [CH_W-1:0]   o_brightness;

    t_hsv hsv_pending_q[$];
    int   error_count    = 0;
    int   src_gap_pct    = 0;   // chance per request of a sender gap
    int   sink_stall_pct = 0;   // chance per cycle of a receiver stall burst
    int   hold_req_cnt   = 0;   // raised by the tests, served by the receiver

    rgb_to_hsv_converter_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // Clock: 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // floor(num * 60deg / den) for |num| <= den, den > 0
    function automatic int sector_offset(input int num, input int den);
        if (num >= 0) begin
            return (num * SIXTY_DEG) / den;
        end
        return -(((-num) * SIXTY_DEG + den - 1) / den);
    endfunction

    // Work out hue, saturation and brightness of one pixel
    function automatic t_hsv convert_pixel(input logic [CH_W-1:0] r, g, b);
        int   mx;
        int   mn;
        int   delta;
        int   h;
        t_hsv res;
        mx = int'(r);
        mn = int'(r);
        if (int'(g) > mx) mx = int'(g);
        if (int'(b) > mx) mx = int'(b);
        if (int'(g) < mn) mn = int'(g);
        if (int'(b) < mn) mn = int'(b);
        delta      = mx - mn;
        res.bright = mx[CH_W-1:0];
        res.sat    = '0;
        res.hue    = '0;
        if (mx != 0) begin
            res.sat = CH_W'((255 * delta) / mx);
            if (delta != 0) begin
                // Sector follows the first channel equal to max: red, green, blue
                if (int'(r) == mx) begin
                    h = sector_offset(int'(g) - int'(b), delta);
                    if (h < 0) h += FULL_TURN;
                end else if (int'(g) == mx) begin
                    h = 2 * SIXTY_DEG + sector_offset(int'(b) - int'(r), delta);
                end else begin
                    h = 4 * SIXTY_DEG + sector_offset(int'(r) - int'(g), delta);
                end
                res.hue = HUE_W'(h);
            end
        end
        return res;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Predict at each input request, compare at each output request
    always @(posedge i_clk) begin : hsv_check
        t_hsv want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (hsv_pending_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual hue %0d sat %0d val %0d",
                             $time, o_hue, o_saturation, o_brightness);
                    error_count++;
                end else begin
                    want = hsv_pending_q.pop_front();
                    if ($isunknown({o_hue, o_saturation, o_brightness})) begin
                        $display("%0t: unknown result, expected hue %0d actual %h",
                                 $time, want.hue, o_hue);
                        error_count++;
                    end else begin
                        report_field("hue", int'(want.hue), int'(o_hue));
                        report_field("saturation", int'(want.sat), int'(o_saturation));
                        report_field("brightness", int'(want.bright), int'(o_brightness));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                hsv_pending_q.push_back(convert_pixel(i_red, i_green, i_blue));
            end
        end
    end

    // Receiver: random stall bursts, plus long hold-offs on request
    initial begin : result_sink
        int stall_left;
        int hold_done_cnt;
        stall_left    = 0;
        hold_done_cnt = 0;
        i_out_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done_cnt != hold_req_cnt) begin
                hold_done_cnt = hold_req_cnt;
                stall_left    = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one pixel, with an optional gap first, and hold it until taken
    task automatic push_pixel(input logic [CH_W-1:0] r, g, b);
        int gap;
        if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (hsv_pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] edge_byte();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Draw one random channel value
    function automatic logic [CH_W-1:0] rand_byte();
        return CH_W'($urandom_range(0, 255));
    endfunction

    // Black, grey, primaries, tied maxima and wrapped red hues
    task automatic test_special_pixels();
        src_gap_pct    = 20;
        sink_stall_pct = 10;
        push_pixel(8'd0,   8'd0,   8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd1,   8'd1,   8'd1);
        push_pixel(8'd128, 8'd128, 8'd128);
        push_pixel(8'd255, 8'd0,   8'd0);
        push_pixel(8'd0,   8'd255, 8'd0);
        push_pixel(8'd0,   8'd0,   8'd255);
        push_pixel(8'd255, 8'd255, 8'd0);
        push_pixel(8'd0,   8'd255, 8'd255);
        push_pixel(8'd255, 8'd0,   8'd255);
        push_pixel(8'd255, 8'd0,   8'd1);
        push_pixel(8'd255, 8'd254, 8'd255);
        push_pixel(8'd1,   8'd0,   8'd0);
        push_pixel(8'd0,   8'd1,   8'd0);
        push_pixel(8'd0,   8'd0,   8'd1);
        push_pixel(8'd254, 8'd255, 8'd0);
        push_pixel(8'd255, 8'd128, 8'd0);
        push_pixel(8'd10,  8'd20,  8'd30);
        push_pixel(8'd200, 8'd100, 8'd201);
        push_pixel(8'd170, 8'd85,  8'd170);
        push_pixel(8'd1,   8'd0,   8'd1);
        push_pixel(8'd0,   8'd254, 8'd255);
    endtask

    // Random pixels from several classes, with idling that varies by block
    task automatic test_random_pixels();
        logic [CH_W-1:0] r, g, b, m, o;
        for (int blk = 0; blk < 6; blk++) begin
            case (blk % 3)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 10; sink_stall_pct = 5;  end
                default: begin src_gap_pct = 35; sink_stall_pct = 25; end
            endcase
            for (int n = 0; n < 150; n++) begin
                r = rand_byte();
                g = rand_byte();
                b = rand_byte();
                case ($urandom_range(0, 5))
                    1: begin
                        g = r;
                        b = r;
                    end
                    2: begin
                        // Two channels share the maximum
                        m = rand_byte();
                        o = CH_W'($urandom_range(0, int'(m)));
                        case ($urandom_range(0, 2))
                            0:       begin r = m; g = m; b = o; end
                            1:       begin r = m; g = o; b = m; end
                            default: begin r = o; g = m; b = m; end
                        endcase
                    end
                    3: begin
                        r = CH_W'($urandom_range(0, 3));
                        g = CH_W'($urandom_range(0, 3));
                        b = CH_W'($urandom_range(0, 3));
                    end
                    4: begin
                        r = edge_byte();
                        g = edge_byte();
                        b = edge_byte();
                    end
                    default: ;
                endcase
                push_pixel(r, g, b);
            end
        end
    endtask

    // Hold the output off while the sender keeps offering, then pause for a full drain
    task automatic test_output_hold();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_req_cnt++;
        for (int n = 0; n < 60; n++) begin
            push_pixel(rand_byte(), rand_byte(), rand_byte());
        end
        wait_drain();
    endtask

    // Back-to-back pixels with no idling on either side
    task automatic test_full_rate();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        for (int n = 0; n < 100; n++) begin
            push_pixel(rand_byte(), rand_byte(), rand_byte());
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_red      = '0;
        i_green    = '0;
        i_blue     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_pixels();
        test_random_pixels();
        test_output_hold();
        test_full_rate();
        wait_drain();

        if (error_count == 0 && hsv_pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rgb2hsv_pkg.sv
hdl/rgb_to_hsv_converter_core.sv
test/tb_rgb_to_hsv_converter_core.sv
